// File: src/tblit_pkg.sv
// Package of the texel to RGBA5551 blit unit: widths, command and register
// codes, the configuration and queue entry types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tblit_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int COORD_BITS    = 11;

	localparam int CMD_BITS      = 4;
	localparam int TEXEL_BITS    = 32;
	localparam int PIX_BITS      = 16;
	localparam int PAL_IDX_BITS  = 8;
	localparam int PAL_ADDR_BITS = $clog2(PALETTE_DEPTH);
	localparam int DIM_BITS      = 11;
	localparam int OUT_X_BITS    = COORD_BITS + 1;
	localparam int OFFSET_BITS   = 20;
	localparam int CLIP_BITS     = (OUT_X_BITS > DIM_BITS) ? OUT_X_BITS : DIM_BITS;
	localparam int PROD_BITS     = COORD_BITS + DIM_BITS;

	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	localparam int FIFO_DEPTH    = 2;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	localparam logic [PAL_IDX_BITS:0] PAL_LIMIT = (PAL_IDX_BITS + 1)'(PALETTE_DEPTH);

	localparam logic [PIX_BITS-1:0] FILL_TRANSPARENT = 16'h0001;
	localparam logic [PIX_BITS-1:0] FLASH_WHITE      = 16'hFFFF;

	localparam logic [DIM_BITS-1:0] ROW_SPAN_RESET  = 11'd320;
	localparam logic [DIM_BITS-1:0] FB_HEIGHT_RESET = 11'd240;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_I4        = 4'd0,
		CMD_IA4       = 4'd1,
		CMD_I8        = 4'd2,
		CMD_IA8       = 4'd3,
		CMD_RGBA16    = 4'd4,
		CMD_RGBA32    = 4'd5,
		CMD_CI4       = 4'd6,
		CMD_CI8       = 4'd7,
		CMD_PAL_WRITE = 4'd8
	} tblit_cmd_t;

	typedef enum logic [1:0] {
		REG_ROW_SPAN  = 2'd0,
		REG_FB_HEIGHT = 2'd1,
		REG_KEEP_BG   = 2'd2,
		REG_CI8_FLASH = 2'd3
	} tblit_reg_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] row_span;
		logic [DIM_BITS-1:0] fb_height;
		logic                keep_background;
		logic                ci8_flash_white;
	} tblit_cfg_t;

	typedef struct packed {
		logic                   two_pix;
		logic [COORD_BITS-1:0]  x;
		logic [COORD_BITS-1:0]  y;
		logic [OFFSET_BITS-1:0] yw;
		logic                   we0;
		logic [PIX_BITS-1:0]    val0;
		logic                   we1;
		logic [PIX_BITS-1:0]    val1;
	} tblit_entry_t;

	typedef struct packed {
		logic         valid;
		tblit_entry_t entry;
	} tblit_head_t;

	function automatic logic pal_in_range(input logic [PAL_IDX_BITS-1:0] idx);
		return {1'b0, idx} < PAL_LIMIT;
	endfunction

endpackage

`default_nettype wire

// File: src/tblit_if.sv
// Channel interfaces of the blit unit: texel items in, pixel writes out.
// Depends on tblit_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tblit_in_if import tblit_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [CMD_BITS-1:0]           command;
	logic [TEXEL_BITS-1:0]         texel;
	logic signed [COORD_BITS-1:0]  pixel_x;
	logic signed [COORD_BITS-1:0]  pixel_y;
	logic [PIX_BITS-1:0]           dest_pixel;
	logic [PAL_IDX_BITS-1:0]       palette_index;
	logic [PIX_BITS-1:0]           palette_value;

	modport source(output valid, command, texel, pixel_x, pixel_y, dest_pixel,
		palette_index, palette_value, input ready);
	modport sink(input valid, command, texel, pixel_x, pixel_y, dest_pixel,
		palette_index, palette_value, output ready);
endinterface

interface tblit_out_if import tblit_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          write_enable;
	logic signed [OUT_X_BITS-1:0]  out_x;
	logic signed [COORD_BITS-1:0]  out_y;
	logic [OFFSET_BITS-1:0]        fb_offset;
	logic [PIX_BITS-1:0]           pixel_value;
	logic                          last;

	modport source(output valid, write_enable, out_x, out_y, fb_offset, pixel_value, last,
		input ready);
	modport sink(input valid, write_enable, out_x, out_y, fb_offset, pixel_value, last,
		output ready);
endinterface

`default_nettype wire

// File: src/tblit_ram.sv
// Generic RAM with one write port and two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tblit_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int ABITS = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [ABITS-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [ABITS-1:0] raddr_a,
	input  logic [ABITS-1:0] raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a_q <= mem_q[raddr_a];
			rdata_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

`default_nettype wire

// File: src/tblit_front.sv
// Front end of the blit unit: takes texel items, owns the palette, converts
// and clips each pixel and pushes one entry per pixel item. Depends on
// tblit_pkg, tblit_if and tblit_ram.
`timescale 1ns / 1ps
`default_nettype none

module tblit_front import tblit_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  tblit_cfg_t   cfg,
	tblit_in_if.sink     texels,
	input  logic         q_full,
	output logic         push,
	output tblit_entry_t push_entry
);

	logic                    accept;
	tblit_cmd_t              cmd_in;
	logic                    is_pix_in;
	logic [PAL_IDX_BITS-1:0] idx_a;
	logic [PAL_IDX_BITS-1:0] idx_b;
	logic                    pal_we;
	logic [PIX_BITS-1:0]     rd_a;
	logic [PIX_BITS-1:0]     rd_b;
	logic [7:0]              alpha_in;
	logic [PIX_BITS-1:0]     src_p [3];
	logic [PIX_BITS-1:0]     dst_p [3];
	logic [PROD_BITS-1:0]    yw_full;

	logic                    valid_s1;
	tblit_cmd_t              cmd_s1;
	logic [PIX_BITS-1:0]     tex_s1;
	logic [COORD_BITS-1:0]   x_s1;
	logic [COORD_BITS-1:0]   y_s1;
	logic [OFFSET_BITS-1:0]  yw_s1;
	logic [PIX_BITS-1:0]     src_s1 [3];
	logic [PIX_BITS-1:0]     dst_s1 [3];
	logic                    rng_a_s1;
	logic                    rng_b_s1;

	logic [PIX_BITS:0]       bsum [3];
	logic [PIX_BITS:0]       bquo [3];
	logic [PIX_BITS-1:0]     blend_c;
	logic [PIX_BITS-1:0]     c_a;
	logic [PIX_BITS-1:0]     c_b;
	logic [7:0]              b_s1;
	logic [4:0]              i8;
	logic                    opq0;
	logic                    opq1;
	logic [PIX_BITS-1:0]     col0;
	logic [PIX_BITS-1:0]     col1;
	logic [PIX_BITS-1:0]     fill0;
	logic                    two_pix;
	logic signed [OUT_X_BITS-1:0] x0;
	logic signed [OUT_X_BITS-1:0] x1;
	logic                    y_in;
	logic                    in0;
	logic                    in1;

	function automatic logic [PIX_BITS-1:0] grey4(input logic [3:0] i);
		return {i, 1'b0, i, 1'b0, i, 1'b0, 1'b1};
	endfunction

	assign accept    = texels.valid & texels.ready;
	assign cmd_in    = tblit_cmd_t'(texels.command);
	assign is_pix_in = texels.command <= CMD_CI8;
	assign texels.ready = ~valid_s1 | ~q_full;
	assign push      = valid_s1 & ~q_full;

	assign idx_a  = (cmd_in == CMD_CI8) ? texels.texel[7:0] : PAL_IDX_BITS'(texels.texel[7:4]);
	assign idx_b  = PAL_IDX_BITS'(texels.texel[3:0]);
	assign pal_we = accept & (cmd_in == CMD_PAL_WRITE) & pal_in_range(texels.palette_index);

	tblit_ram #(
		.WIDTH(PIX_BITS),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk    (clk),
		.we     (pal_we),
		.waddr  (texels.palette_index[PAL_ADDR_BITS-1:0]),
		.wdata  (texels.palette_value),
		.re     (accept),
		.raddr_a(idx_a[PAL_ADDR_BITS-1:0]),
		.raddr_b(idx_b[PAL_ADDR_BITS-1:0]),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	assign alpha_in = texels.texel[7:0];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			src_p[k] = PIX_BITS'(texels.texel[31 - 8 * k -: 8]) * PIX_BITS'(alpha_in);
			dst_p[k] = PIX_BITS'({texels.dest_pixel[15 - 5 * k -: 5], 3'b000})
				* PIX_BITS'(8'd255 - alpha_in);
		end
	end

	assign yw_full = PROD_BITS'($unsigned(texels.pixel_y)) * PROD_BITS'(cfg.row_span);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= is_pix_in;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd_in;
			tex_s1   <= texels.texel[PIX_BITS-1:0];
			x_s1     <= texels.pixel_x;
			y_s1     <= texels.pixel_y;
			yw_s1    <= OFFSET_BITS'(yw_full);
			rng_a_s1 <= pal_in_range(idx_a);
			rng_b_s1 <= pal_in_range(idx_b);
			for (int k = 0; k < 3; k++) begin
				src_s1[k] <= src_p[k];
				dst_s1[k] <= dst_p[k];
			end
		end
	end

	// Division by 255 as (s + 1 + (s >> 8)) >> 8, exact over the blend range.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			bsum[k] = (PIX_BITS + 1)'(src_s1[k]) + (PIX_BITS + 1)'(dst_s1[k]);
			bquo[k] = (bsum[k] + (PIX_BITS + 1)'(1) + (bsum[k] >> 8)) >> 8;
		end
		blend_c = {bquo[0][7:3], bquo[1][7:3], bquo[2][7:3], 1'b1};
	end

	assign b_s1 = tex_s1[7:0];
	assign i8   = b_s1[7:3];
	assign c_a  = rng_a_s1 ? rd_a : '0;
	assign c_b  = rng_b_s1 ? rd_b : '0;

	always_comb begin
		opq0    = 1'b0;
		opq1    = 1'b0;
		col0    = '0;
		col1    = '0;
		fill0   = FILL_TRANSPARENT;
		two_pix = 1'b0;
		unique case (cmd_s1)
			CMD_I4: begin
				two_pix = 1'b1;
				opq0    = b_s1[7:4] != 4'd0;
				opq1    = b_s1[3:0] != 4'd0;
				col0    = grey4(b_s1[7:4]);
				col1    = grey4(b_s1[3:0]);
			end
			CMD_IA4: begin
				two_pix = 1'b1;
				opq0    = b_s1[4];
				opq1    = b_s1[0];
				col0    = grey4({b_s1[7:5], 1'b0});
				col1    = grey4({b_s1[3:1], 1'b0});
			end
			CMD_CI4: begin
				two_pix = 1'b1;
				opq0    = c_a[0];
				opq1    = c_b[0];
				col0    = c_a;
				col1    = c_b;
			end
			CMD_I8: begin
				opq0 = i8 != 5'd0;
				col0 = {i8, i8, i8, 1'b1};
			end
			CMD_IA8: begin
				opq0 = b_s1[3:0] != 4'd0;
				col0 = grey4(b_s1[7:4]);
			end
			CMD_RGBA16: begin
				opq0  = tex_s1[0];
				col0  = tex_s1;
				fill0 = tex_s1 | FILL_TRANSPARENT;
			end
			CMD_RGBA32: begin
				opq0 = b_s1 != 8'd0;
				col0 = blend_c;
			end
			CMD_CI8: begin
				opq0 = c_a[0];
				col0 = c_a;
				if (c_a[PIX_BITS-1:1] != '0) begin
					fill0 = cfg.ci8_flash_white ? FLASH_WHITE : (c_a | FILL_TRANSPARENT);
				end
			end
			default: begin
				two_pix = 1'b0;
			end
		endcase
	end

	assign x0   = OUT_X_BITS'($signed(x_s1));
	assign x1   = x0 + OUT_X_BITS'(1);
	assign y_in = ~y_s1[COORD_BITS-1]
		& (CLIP_BITS'($unsigned(y_s1)) < CLIP_BITS'(cfg.fb_height));
	assign in0  = y_in & ~x0[OUT_X_BITS-1]
		& (CLIP_BITS'($unsigned(x0)) < CLIP_BITS'(cfg.row_span));
	assign in1  = y_in & ~x1[OUT_X_BITS-1]
		& (CLIP_BITS'($unsigned(x1)) < CLIP_BITS'(cfg.row_span));

	always_comb begin
		push_entry.two_pix = two_pix;
		push_entry.x       = x_s1;
		push_entry.y       = y_s1;
		push_entry.yw      = yw_s1;
		push_entry.we0     = in0 & (opq0 | ~cfg.keep_background);
		push_entry.val0    = opq0 ? col0 : fill0;
		push_entry.we1     = in1 & (opq1 | ~cfg.keep_background);
		push_entry.val1    = opq1 ? col1 : FILL_TRANSPARENT;
	end

endmodule

`default_nettype wire

// File: src/tblit_fifo.sv
// Two-entry queue between the front and back ends of the blit unit.
// Depends on tblit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tblit_fifo import tblit_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  tblit_entry_t push_entry,
	output logic         full,
	input  logic         pop,
	output tblit_head_t  head
);

	tblit_entry_t             store_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] count_q;

	assign full       = count_q == FIFO_CNT_BITS'(FIFO_DEPTH);
	assign head.valid = count_q != '0;
	assign head.entry = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

// File: src/tblit_back.sv
// Back end of the blit unit: walks the pixels of each queued entry, forms
// the framebuffer offset and holds the result in the output register.
// Depends on tblit_pkg and tblit_if.
`timescale 1ns / 1ps
`default_nettype none

module tblit_back import tblit_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  tblit_head_t  head,
	output logic         pop,
	tblit_out_if.source  pixels
);

	logic                         load;
	logic                         second;
	logic                         we;
	logic signed [OUT_X_BITS-1:0] xs;
	logic signed [OUT_X_BITS-1:0] xpix;
	logic [OFFSET_BITS-1:0]       offset;

	logic                         out_valid_q;
	logic                         phase_q;
	logic                         we_q;
	logic [OUT_X_BITS-1:0]        x_q;
	logic [COORD_BITS-1:0]        y_q;
	logic [OFFSET_BITS-1:0]       off_q;
	logic [PIX_BITS-1:0]          val_q;
	logic                         last_q;

	assign load   = head.valid & (~out_valid_q | pixels.ready);
	assign second = head.entry.two_pix & ~phase_q;
	assign pop    = load & ~second;

	assign we     = phase_q ? head.entry.we1 : head.entry.we0;
	assign xs     = OUT_X_BITS'($signed(head.entry.x));
	assign xpix   = phase_q ? xs + OUT_X_BITS'(1) : xs;
	assign offset = OFFSET_BITS'($unsigned(xpix)) + head.entry.yw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= second;
			end else if (pixels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			we_q   <= we;
			x_q    <= xpix;
			y_q    <= head.entry.y;
			off_q  <= we ? offset : '0;
			val_q  <= we ? (phase_q ? head.entry.val1 : head.entry.val0) : '0;
			last_q <= ~second;
		end
	end

	assign pixels.valid        = out_valid_q;
	assign pixels.write_enable = we_q;
	assign pixels.out_x        = x_q;
	assign pixels.out_y        = y_q;
	assign pixels.fb_offset    = off_q;
	assign pixels.pixel_value  = val_q;
	assign pixels.last         = last_q;

endmodule

`default_nettype wire

// File: src/texel_to_rgba5551_blit_unit.sv
// Top level of the texel to RGBA5551 blit unit: configuration registers,
// front end, queue and back end. Depends on tblit_pkg, tblit_if,
// tblit_front, tblit_fifo and tblit_back.
//
//   channel  direction  beat
//   texels   in         one texel of a format, or one palette write
//   pixels   out        one framebuffer pixel write, last marks the item's end
//   apb      in/out     one configuration register access
//
// One result beat per cycle while the output is ready: 4-bit formats give two
// beats, the others one; palette writes and unused commands give none.
// An item passes the palette read and the products, the queue and the output
// register on its way to its first result beat.
// Reset clears the configuration to its defaults and empties the pipeline; the
// palette holds nothing until written. A two-entry queue lets either side stall.
`timescale 1ns / 1ps
`default_nettype none

module texel_to_rgba5551_blit_unit import tblit_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	tblit_in_if.sink                 texels,
	tblit_out_if.source              pixels
);

	tblit_cfg_t   cfg_q;
	tblit_reg_t   reg_sel;
	logic         cfg_write;
	logic         q_full;
	logic         push;
	logic         pop;
	tblit_entry_t push_entry;
	tblit_head_t  head;

	assign pready    = 1'b1;
	assign reg_sel   = tblit_reg_t'(paddr[3:2]);
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_span        <= ROW_SPAN_RESET;
			cfg_q.fb_height       <= FB_HEIGHT_RESET;
			cfg_q.keep_background <= 1'b1;
			cfg_q.ci8_flash_white <= 1'b0;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_ROW_SPAN:  cfg_q.row_span        <= pwdata[DIM_BITS-1:0];
				REG_FB_HEIGHT: cfg_q.fb_height       <= pwdata[DIM_BITS-1:0];
				REG_KEEP_BG:   cfg_q.keep_background <= pwdata[0];
				REG_CI8_FLASH: cfg_q.ci8_flash_white <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ROW_SPAN:  prdata = APB_DATA_BITS'(cfg_q.row_span);
			REG_FB_HEIGHT: prdata = APB_DATA_BITS'(cfg_q.fb_height);
			REG_KEEP_BG:   prdata = APB_DATA_BITS'(cfg_q.keep_background);
			REG_CI8_FLASH: prdata = APB_DATA_BITS'(cfg_q.ci8_flash_white);
			default:       prdata = '0;
		endcase
	end

	tblit_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.texels    (texels),
		.q_full    (q_full),
		.push      (push),
		.push_entry(push_entry)
	);

	tblit_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	tblit_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.pixels(pixels)
	);

endmodule

`default_nettype wire

// File: tb/tblit_pixel_checker.sv
// Checker of the texel to RGBA5551 blit unit: follows the APB writes and the texel
// beats, predicts every pixel write and compares it with the pixel beats.
// Depends on tblit_pkg and tblit_if.
`timescale 1ns / 1ps
`default_nettype none

module tblit_pixel_checker import tblit_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	tblit_in_if                      texels,
	tblit_out_if                     pixels,
	output int                       mismatches,
	output int                       outstanding
);

	typedef struct packed {
		logic                   we;
		logic [OUT_X_BITS-1:0]  x;
		logic [COORD_BITS-1:0]  y;
		logic [OFFSET_BITS-1:0] offset;
		logic [PIX_BITS-1:0]    color;
		logic                   last;
	} pixel_write_t;

	pixel_write_t        due_writes[$];
	logic [DIM_BITS-1:0] width_now;
	logic [DIM_BITS-1:0] height_now;
	logic                keep_bg_now;
	logic                flash_now;
	logic [PIX_BITS-1:0] palette_copy [PALETTE_DEPTH];

	function automatic logic [PIX_BITS-1:0] grey_from_nibble(input logic [3:0] level);
		return {level, 1'b0, level, 1'b0, level, 1'b0, 1'b1};
	endfunction

	function automatic logic [4:0] blend_channel(input int src8, input int dst5, input int alpha);
		int mixed;
		mixed = (src8 * alpha + dst5 * 8 * (255 - alpha)) / 255;
		return 5'(mixed >> 3);
	endfunction

	function automatic void queue_pixel(input int x, input int y, input logic opaque,
			input logic [PIX_BITS-1:0] color, input logic [PIX_BITS-1:0] fill,
			input logic is_last);
		pixel_write_t w;
		logic         draw;
		logic         on_screen;
		draw      = opaque || !keep_bg_now;
		on_screen = x >= 0 && x < int'(width_now) && y >= 0 && y < int'(height_now);
		w.we      = on_screen && draw;
		w.x       = OUT_X_BITS'(x);
		w.y       = COORD_BITS'(y);
		w.offset  = w.we ? OFFSET_BITS'(x + y * int'(width_now)) : '0;
		w.color   = w.we ? (opaque ? color : fill) : '0;
		w.last    = is_last;
		due_writes.push_back(w);
	endfunction

	function automatic void convert_texel(input tblit_cmd_t cmd, input logic [TEXEL_BITS-1:0] tex,
			input int x, input int y, input logic [PIX_BITS-1:0] dst,
			input logic [PAL_IDX_BITS-1:0] pidx, input logic [PIX_BITS-1:0] pval);
		logic [7:0]          b;
		logic [3:0]          nib;
		logic [4:0]          level;
		logic [7:0]          alpha;
		logic [PIX_BITS-1:0] c;
		logic [PIX_BITS-1:0] fill;
		b = tex[7:0];
		case (cmd)
			CMD_I4, CMD_IA4, CMD_CI4: begin
				for (int k = 0; k < 2; k++) begin
					nib = (k == 0) ? b[7:4] : b[3:0];
					if (cmd == CMD_I4) begin
						queue_pixel(x + k, y, nib != 0, grey_from_nibble(nib),
							FILL_TRANSPARENT, k == 1);
					end else if (cmd == CMD_IA4) begin
						queue_pixel(x + k, y, nib[0], grey_from_nibble({nib[3:1], 1'b0}),
							FILL_TRANSPARENT, k == 1);
					end else begin
						c = palette_copy[nib];
						queue_pixel(x + k, y, c[0], c, FILL_TRANSPARENT, k == 1);
					end
				end
			end
			CMD_I8: begin
				level = b[7:3];
				queue_pixel(x, y, level != 0, {level, level, level, 1'b1}, FILL_TRANSPARENT, 1'b1);
			end
			CMD_IA8: begin
				queue_pixel(x, y, b[3:0] != 0, grey_from_nibble(b[7:4]), FILL_TRANSPARENT, 1'b1);
			end
			CMD_RGBA16: begin
				c = tex[PIX_BITS-1:0];
				queue_pixel(x, y, c[0], c, c | 16'h0001, 1'b1);
			end
			CMD_RGBA32: begin
				alpha = tex[7:0];
				c = {blend_channel(tex[31:24], dst[15:11], alpha),
					blend_channel(tex[23:16], dst[10:6], alpha),
					blend_channel(tex[15:8], dst[5:1], alpha), 1'b1};
				queue_pixel(x, y, alpha != 0, c, FILL_TRANSPARENT, 1'b1);
			end
			CMD_CI8: begin
				c = palette_copy[b];
				if (c[PIX_BITS-1:1] != 0)
					fill = flash_now ? FLASH_WHITE : (c | 16'h0001);
				else
					fill = FILL_TRANSPARENT;
				queue_pixel(x, y, c[0], c, fill, 1'b1);
			end
			CMD_PAL_WRITE: begin
				if (pal_in_range(pidx))
					palette_copy[pidx] = pval;
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_write_t want;
		if (!arst_n) begin
			width_now   = ROW_SPAN_RESET;
			height_now  = FB_HEIGHT_RESET;
			keep_bg_now = 1'b1;
			flash_now   = 1'b0;
			mismatches  = 0;
			due_writes.delete();
		end else begin
			if (pixels.valid && pixels.ready) begin
				if (due_writes.size() == 0) begin
					$error("pixel beat with no write pending: x 0x%0h y 0x%0h",
						pixels.out_x, pixels.out_y);
					mismatches++;
				end else begin
					want = due_writes.pop_front();
					check_field("write_enable", want.we, pixels.write_enable);
					check_field("out_x", want.x, $unsigned(pixels.out_x));
					check_field("out_y", want.y, $unsigned(pixels.out_y));
					check_field("fb_offset", want.offset, pixels.fb_offset);
					check_field("pixel_value", want.color, pixels.pixel_value);
					check_field("last", want.last, pixels.last);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (tblit_reg_t'(paddr[APB_ADDR_BITS-1:2]))
					REG_ROW_SPAN:  width_now   = pwdata[DIM_BITS-1:0];
					REG_FB_HEIGHT: height_now  = pwdata[DIM_BITS-1:0];
					REG_KEEP_BG:   keep_bg_now = pwdata[0];
					REG_CI8_FLASH: flash_now   = pwdata[0];
					default: ;
				endcase
			end
			if (texels.valid && texels.ready) begin
				convert_texel(tblit_cmd_t'(texels.command), texels.texel, int'(texels.pixel_x),
					int'(texels.pixel_y), texels.dest_pixel, texels.palette_index,
					texels.palette_value);
			end
		end
		outstanding = due_writes.size();
	end

endmodule

`default_nettype wire

// File: tb/texel_to_rgba5551_blit_unit_tb.sv
// Top of the blit unit testbench: clock, reset, APB writes, texel stimulus and
// random output stalls; the verdict comes from the checker's mismatch count.
// Depends on tblit_pkg, tblit_if, tblit_pixel_checker and the blit unit.
`timescale 1ns / 1ps
`default_nettype none

module texel_to_rgba5551_blit_unit_tb import tblit_pkg::*; ();

	localparam int CYCLE_LIMIT = 400_000;
	localparam int PHASES      = 9;
	localparam int RANDOM_SIZE = -1;
	localparam int COORD_SPAN  = 1 << (COORD_BITS - 1);

	localparam int PHASE_W     [PHASES] = '{1024, 1, 320, 1024, 1, 0, 2047, RANDOM_SIZE, 640};
	localparam int PHASE_H     [PHASES] = '{1024, 1, 240, 1, 1024, 2047, 7, RANDOM_SIZE, 480};
	localparam int PHASE_KEEP  [PHASES] = '{0, 1, 0, 1, 1, 0, 0, 0, 0};
	localparam int PHASE_FLASH [PHASES] = '{1, 0, 0, 1, 0, 1, 1, 0, 1};
	localparam int PHASE_ITEMS [PHASES] = '{130, 110, 130, 110, 110, 40, 60, 130, 140};
	localparam int GAP_PCT     [3]      = '{0, 15, 35};

	localparam logic [CMD_BITS-1:0] CMD_UNUSED_LO = CMD_PAL_WRITE + 1;
	localparam logic [CMD_BITS-1:0] CMD_UNUSED_HI = '1;

	typedef struct {
		logic [CMD_BITS-1:0]          cmd;
		logic [TEXEL_BITS-1:0]        tex;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [PIX_BITS-1:0]          dst;
		logic [PAL_IDX_BITS-1:0]      pidx;
		logic [PIX_BITS-1:0]          pval;
	} texel_item_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int mismatches;
	int outstanding;
	int cycles       = 0;
	int src_gap_pct  = 15;
	int sink_gap_pct = 15;
	bit pal_loaded [PALETTE_DEPTH];

	tblit_in_if  texel_ch ();
	tblit_out_if pixel_ch ();

	texel_to_rgba5551_blit_unit DUT (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready,
		.texels(texel_ch),
		.pixels(pixel_ch)
	);

	tblit_pixel_checker pixel_check (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.pready,
		.paddr,
		.pwdata,
		.texels(texel_ch),
		.pixels(pixel_ch),
		.mismatches,
		.outstanding
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int hold;
		pixel_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (sink_gap_pct != 0 && $urandom_range(1, 100) <= sink_gap_pct) begin
				hold = $urandom_range(1, 13);
				pixel_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			pixel_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	function automatic texel_item_t make_item(input logic [CMD_BITS-1:0] cmd,
			input logic [TEXEL_BITS-1:0] tex, input int x, input int y,
			input logic [PIX_BITS-1:0] dst);
		texel_item_t it;
		it.cmd  = cmd;
		it.tex  = tex;
		it.x    = COORD_BITS'(x);
		it.y    = COORD_BITS'(y);
		it.dst  = dst;
		it.pidx = PAL_IDX_BITS'($urandom);
		it.pval = PIX_BITS'($urandom);
		return it;
	endfunction

	function automatic texel_item_t load_item(input int idx, input logic [PIX_BITS-1:0] value);
		texel_item_t it;
		it = make_item(CMD_PAL_WRITE, $urandom, $urandom, $urandom, PIX_BITS'($urandom));
		it.pidx = PAL_IDX_BITS'(idx);
		it.pval = value;
		pal_loaded[idx] = 1'b1;
		return it;
	endfunction

	function automatic int pick_loaded(input int span);
		int idx;
		repeat (32) begin
			idx = $urandom_range(0, span - 1);
			if (pal_loaded[idx])
				return idx;
		end
		return 0;
	endfunction

	function automatic texel_item_t random_texel(input int w, input int h);
		texel_item_t it;
		int          span_x;
		int          span_y;
		int          roll;
		span_x = (w > COORD_SPAN) ? COORD_SPAN : w;
		span_y = (h > COORD_SPAN) ? COORD_SPAN : h;
		it = make_item(CMD_BITS'($urandom_range(CMD_I4, CMD_CI8)), $urandom, $urandom,
			$urandom, PIX_BITS'($urandom));
		if ($urandom_range(0, 9) < 7) begin
			if (span_x > 0)
				it.x = COORD_BITS'($urandom_range(0, span_x - 1));
			if (span_y > 0)
				it.y = COORD_BITS'($urandom_range(0, span_y - 1));
		end
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return load_item((roll < 5) ? $urandom_range(0, 15) :
				$urandom_range(0, PALETTE_DEPTH - 1), PIX_BITS'($urandom));
		if (roll < 14) begin
			it.cmd = CMD_BITS'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
			return it;
		end
		case (it.cmd)
			CMD_RGBA32: begin
				roll = $urandom_range(0, 9);
				if (roll < 2)
					it.tex[7:0] = 8'h00;
				else if (roll < 4)
					it.tex[7:0] = 8'hFF;
			end
			CMD_CI4: it.tex[7:0] = {4'(pick_loaded(16)), 4'(pick_loaded(16))};
			CMD_CI8: it.tex[7:0] = 8'(pick_loaded(PALETTE_DEPTH));
			default: ;
		endcase
		return it;
	endfunction

	task automatic send_texel(input texel_item_t it);
		int gap;
		if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct) begin
			gap = $urandom_range(1, 13);
			texel_ch.valid   <= 1'b0;
			texel_ch.command <= CMD_BITS'($urandom);
			texel_ch.texel   <= $urandom;
			repeat (gap) @(posedge clk);
		end
		texel_ch.valid         <= 1'b1;
		texel_ch.command       <= it.cmd;
		texel_ch.texel         <= it.tex;
		texel_ch.pixel_x       <= it.x;
		texel_ch.pixel_y       <= it.y;
		texel_ch.dest_pixel    <= it.dst;
		texel_ch.palette_index <= it.pidx;
		texel_ch.palette_value <= it.pval;
		do @(posedge clk); while (!texel_ch.ready);
	endtask

	task automatic wait_idle();
		texel_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input tblit_reg_t idx, input int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		texel_item_t it;
		int          w;
		int          h;
		int          keep;
		int          flash;
		int          sent;
		arst_n                 <= 1'b0;
		psel                   <= 1'b0;
		penable                <= 1'b0;
		pwrite                 <= 1'b0;
		paddr                  <= '0;
		pwdata                 <= '0;
		texel_ch.valid         <= 1'b0;
		texel_ch.command       <= '0;
		texel_ch.texel         <= '0;
		texel_ch.pixel_x       <= '0;
		texel_ch.pixel_y       <= '0;
		texel_ch.dest_pixel    <= '0;
		texel_ch.palette_index <= '0;
		texel_ch.palette_value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_texel(load_item(0, 16'h0000));
		send_texel(load_item(1, 16'hF801));
		send_texel(load_item(15, 16'h07C0));
		send_texel(load_item(PALETTE_DEPTH - 1, 16'hFFFF));
		send_texel(load_item(128, 16'h003E));
		send_texel(make_item(CMD_I4, 32'hFFFF_FFF0, 0, 0, 16'h0000));
		send_texel(make_item(CMD_IA4, 32'h0000_001E, 318, 239, 16'hFFFF));
		send_texel(make_item(CMD_I8, 32'h0000_00FF, 319, 239, 16'h0000));
		send_texel(make_item(CMD_IA8, 32'h0000_000F, -1, 0, 16'h0000));
		send_texel(make_item(CMD_RGBA16, 32'hFFFF_FFFF, 0, 240, 16'h0000));
		send_texel(make_item(CMD_RGBA16, 32'h0000_F801, 319, 0, 16'h0000));
		send_texel(make_item(CMD_RGBA32, 32'hFF00_FF80, 100, 100, 16'hAAAA));
		send_texel(make_item(CMD_CI4, 32'h0000_001F, 319, 5, 16'h0000));
		send_texel(make_item(CMD_CI8, 32'h0000_0080, 10, 10, 16'h0000));
		send_texel(make_item(CMD_UNUSED_LO, 32'h0000_00FF, 1, 1, 16'h0000));
		send_texel(make_item(CMD_UNUSED_HI, 32'h0000_00FF, 2, 2, 16'h0000));
		wait_idle();
		reg_write(REG_KEEP_BG, 0);
		reg_write(REG_CI8_FLASH, 1);
		send_texel(make_item(CMD_I4, 32'h0000_000F, -1024, -1024, 16'h0000));
		send_texel(make_item(CMD_IA4, 32'h0000_00E1, 1023, 1023, 16'h0000));
		send_texel(make_item(CMD_I8, 32'h0000_0007, 5, 5, 16'h0000));
		send_texel(make_item(CMD_IA8, 32'h0000_00F0, 6, 6, 16'h0000));
		send_texel(make_item(CMD_RGBA16, 32'h0000_1234, 7, 7, 16'h0000));
		send_texel(make_item(CMD_RGBA32, 32'h1234_5600, 8, 8, 16'h5555));
		send_texel(make_item(CMD_RGBA32, 32'hFFFF_FFFF, 9, 9, 16'h0000));
		send_texel(make_item(CMD_CI8, 32'h0000_0080, 11, 11, 16'h0000));
		send_texel(make_item(CMD_CI8, 32'h0000_0000, 12, 12, 16'h0000));
		send_texel(make_item(CMD_CI4, 32'h0000_00F0, 0, 239, 16'h0000));
		send_texel(make_item(CMD_CI8, 32'h0000_00FF, 319, 239, 16'h0000));

		for (int ph = 0; ph < PHASES; ph++) begin
			w     = PHASE_W[ph];
			h     = PHASE_H[ph];
			keep  = PHASE_KEEP[ph];
			flash = PHASE_FLASH[ph];
			if (w == RANDOM_SIZE) begin
				w     = $urandom_range(1, 1024);
				h     = $urandom_range(1, 1024);
				keep  = $urandom_range(0, 1);
				flash = $urandom_range(0, 1);
			end
			wait_idle();
			reg_write(REG_ROW_SPAN, w);
			reg_write(REG_FB_HEIGHT, h);
			reg_write(REG_KEEP_BG, keep);
			reg_write(REG_CI8_FLASH, flash);
			if (ph == PHASES - 1) begin
				src_gap_pct  = 0;
				sink_gap_pct = 0;
			end else begin
				src_gap_pct  = GAP_PCT[$urandom_range(0, 2)];
				sink_gap_pct = GAP_PCT[$urandom_range(0, 2)];
			end
			sent = 0;
			while (sent < PHASE_ITEMS[ph]) begin
				it = random_texel(w, h);
				send_texel(it);
				if (it.cmd <= CMD_PAL_WRITE)
					sent++;
			end
		end
		wait_idle();

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
src/tblit_pkg.sv
src/tblit_if.sv
src/tblit_ram.sv
src/tblit_front.sv
src/tblit_fifo.sv
src/tblit_back.sv
src/texel_to_rgba5551_blit_unit.sv
tb/tblit_pixel_checker.sv
tb/texel_to_rgba5551_blit_unit_tb.sv
